### rtl/mcbt_pkg.sv
package mcbt_pkg;

	// field widths of the command and result beats
	localparam int KIND_W   = 2;
	localparam int CHAN_W   = 3;
	localparam int MODE_W   = 3;
	localparam int TMO_IN_W = 24;
	localparam int PERIOD_W = 8;
	localparam int PINS_W   = 8;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	// command kinds
	localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	// channel modes
	localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FAST   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ON     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd4;

	// channel status codes
	localparam logic [STATUS_W-1:0] ST_ON    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OFF   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FLASH = 2'd2;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD = 1'b1;
	localparam logic [PERIOD_W-1:0]  SLOW_PERIOD_RST = 8'd50;
	localparam logic [PERIOD_W-1:0]  FAST_PERIOD_RST = 8'd25;

	// per-channel control bits kept in flops
	typedef struct packed {
		logic                pin;
		logic [STATUS_W-1:0] status;
	} chan_ctl_t;

	// what the update logic is asked to do
	typedef struct packed {
		logic                tick;
		logic [MODE_W-1:0]   mode;
		logic [PERIOD_W-1:0] cfg_period;
	} upd_cmd_t;

endpackage

### rtl/mcbt_chan_upd.sv
module mcbt_chan_upd #(
	parameter int TIMEOUT_BITS = 24
) (
	input  mcbt_pkg::upd_cmd_t             cmd,
	input  mcbt_pkg::chan_ctl_t            cur_ctl,
	input  logic [mcbt_pkg::PERIOD_W-1:0]  cur_period,
	input  logic [mcbt_pkg::PERIOD_W-1:0]  cur_count,
	input  logic [TIMEOUT_BITS-1:0]        cur_timeout,
	input  logic [TIMEOUT_BITS-1:0]        set_timeout,
	output mcbt_pkg::chan_ctl_t            nxt_ctl,
	output logic [mcbt_pkg::PERIOD_W-1:0]  nxt_period,
	output logic [mcbt_pkg::PERIOD_W-1:0]  nxt_count,
	output logic [TIMEOUT_BITS-1:0]        nxt_timeout
);
	import mcbt_pkg::*;

	// next state of one channel for a tick or a set command
	always_comb begin
		logic [PERIOD_W-1:0]     cnt;
		logic [TIMEOUT_BITS-1:0] tmo;
		nxt_ctl     = cur_ctl;
		nxt_period  = cur_period;
		nxt_count   = cur_count;
		nxt_timeout = cur_timeout;
		cnt         = cur_count;
		tmo         = cur_timeout;
		if (cmd.tick) begin
			// flash countdown first
			if (cur_ctl.status == ST_FLASH) begin
				if (cnt != '0)
					cnt = cnt - 1'b1;
				if (cnt == '0) begin
					nxt_ctl.pin = ~cur_ctl.pin;
					cnt = cur_period;
				end
				nxt_count = cnt;
			end
			// then the timeout, expiry forces the pin off
			if (cur_timeout != '0) begin
				tmo = cur_timeout - 1'b1;
				if (tmo == '0) begin
					nxt_ctl.pin    = 1'b0;
					nxt_ctl.status = ST_OFF;
				end
				nxt_timeout = tmo;
			end
		end else begin
			nxt_timeout = set_timeout;
			unique case (cmd.mode) inside
				MODE_SLOW, MODE_FAST: begin
					nxt_ctl.status = ST_FLASH;
					nxt_period     = cmd.cfg_period;
					nxt_count      = '0;
				end
				MODE_OFF: begin
					nxt_ctl.pin    = 1'b0;
					nxt_ctl.status = ST_OFF;
				end
				MODE_ON: begin
					nxt_ctl.pin    = 1'b1;
					nxt_ctl.status = ST_ON;
				end
				MODE_TOGGLE: begin
					nxt_ctl.pin    = ~cur_ctl.pin;
					nxt_ctl.status = cur_ctl.pin ? ST_OFF : ST_ON;
				end
				default: begin
					nxt_timeout = cur_timeout;
				end
			endcase
		end
	end

endmodule

### rtl/multi_channel_blink_timeout_ctrl_unit.sv
// channel   beat marked by            fields
// command   start & !busy             kind, channel, mode, timeout_ticks
// result    done (one cycle)          pin_levels, channel_status
// config    cfg_valid & cfg_ready     cfg_index, cfg_data (cfg_ready is always high)
//
// period, countdown and timeout of each channel sit in one memory with a
// registered read; every access is a read then a write-back.
// set: read, write-back, result; tick: read and write-back of each channel in turn,
// then result; query or rejected command: result; busy drops as done rises.
// arst_n resets all flops but rd_q; unwritten memory entries read as zero.
// the receiver cannot stall: done is high for one cycle; the fields then hold.
module multi_channel_blink_timeout_ctrl_unit #(
	parameter int CHANNELS     = 8,
	parameter int TIMEOUT_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [mcbt_pkg::KIND_W-1:0]       kind,
	input  logic [mcbt_pkg::CHAN_W-1:0]       channel,
	input  logic [mcbt_pkg::MODE_W-1:0]       mode,
	input  logic [mcbt_pkg::TMO_IN_W-1:0]     timeout_ticks,
	output logic                              done,
	output logic [mcbt_pkg::PINS_W-1:0]       pin_levels,
	output logic [mcbt_pkg::STATUS_W-1:0]     channel_status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mcbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcbt_pkg::PERIOD_W-1:0]     cfg_data
);
	import mcbt_pkg::*;

	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WORD_W = 2 * PERIOD_W + TIMEOUT_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET_RD,
		S_SET_WR,
		S_TICK_RD,
		S_TICK_WR,
		S_RESP
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        addr_q;
	logic [IDX_W-1:0]        chan_q;
	logic                    chan_ok_q;
	logic [MODE_W-1:0]       mode_q;
	logic [TIMEOUT_BITS-1:0] tmo_q;
	logic                    done_q;
	logic [PINS_W-1:0]       pin_levels_q;
	logic [STATUS_W-1:0]     status_q;

	logic [PERIOD_W-1:0]     slow_q;
	logic [PERIOD_W-1:0]     fast_q;

	logic [CHANNELS-1:0]     pin_q;
	logic [STATUS_W-1:0]     stat_q [CHANNELS];
	logic [CHANNELS-1:0]     valid_q;

	logic [WORD_W-1:0]       mem [CHANNELS];
	logic [WORD_W-1:0]       rd_q;

	logic                    chan_ok;
	logic                    write_back;
	logic [WORD_W-1:0]       rd_eff;
	logic [WORD_W-1:0]       wr_word;
	logic [PINS_W-1:0]       pins_show;
	upd_cmd_t                cmd;
	chan_ctl_t               cur_ctl;
	chan_ctl_t               nxt_ctl;
	logic [PERIOD_W-1:0]     nxt_period;
	logic [PERIOD_W-1:0]     nxt_count;
	logic [TIMEOUT_BITS-1:0] nxt_timeout;

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign pin_levels     = pin_levels_q;
	assign channel_status = status_q;
	assign cfg_ready      = 1'b1;

	assign chan_ok    = (32'(channel) < CHANNELS);
	assign write_back = (state_q == S_SET_WR) || (state_q == S_TICK_WR);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q <= SLOW_PERIOD_RST;
			fast_q <= FAST_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SLOW_PERIOD: slow_q <= cfg_data;
				REG_FAST_PERIOD: fast_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// channel memory, registered read
	always_ff @(posedge clk) begin
		if (write_back)
			mem[addr_q] <= wr_word;
		rd_q <= mem[addr_q];
	end

	// never-written entries read as zero
	assign rd_eff = valid_q[addr_q] ? rd_q : '0;

	assign cur_ctl.pin    = pin_q[addr_q];
	assign cur_ctl.status = stat_q[addr_q];

	assign cmd.tick       = (state_q == S_TICK_WR);
	assign cmd.mode       = mode_q;
	assign cmd.cfg_period = (mode_q == MODE_FAST) ? fast_q : slow_q;

	mcbt_chan_upd #(
		.TIMEOUT_BITS(TIMEOUT_BITS)
	) u_upd (
		.cmd        (cmd),
		.cur_ctl    (cur_ctl),
		.cur_period (rd_eff[WORD_W-1 -: PERIOD_W]),
		.cur_count  (rd_eff[TIMEOUT_BITS +: PERIOD_W]),
		.cur_timeout(rd_eff[TIMEOUT_BITS-1:0]),
		.set_timeout(tmo_q),
		.nxt_ctl    (nxt_ctl),
		.nxt_period (nxt_period),
		.nxt_count  (nxt_count),
		.nxt_timeout(nxt_timeout)
	);

	assign wr_word = {nxt_period, nxt_count, nxt_timeout};

	// pin and status flops, written back with the memory entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q   <= '0;
			valid_q <= '0;
			for (int c = 0; c < CHANNELS; c++)
				stat_q[c] <= ST_ON;
		end else if (write_back) begin
			pin_q[addr_q]   <= nxt_ctl.pin;
			stat_q[addr_q]  <= nxt_ctl.status;
			valid_q[addr_q] <= 1'b1;
		end
	end

	// pins shown on the result, channels beyond the count read low
	always_comb begin
		pins_show = '0;
		for (int c = 0; c < PINS_W && c < CHANNELS; c++)
			pins_show[c] = pin_q[c];
	end

	// command sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			addr_q       <= '0;
			chan_q       <= '0;
			chan_ok_q    <= 1'b0;
			mode_q       <= MODE_SLOW;
			tmo_q        <= '0;
			done_q       <= 1'b0;
			pin_levels_q <= '0;
			status_q     <= ST_ON;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						chan_q    <= IDX_W'(channel);
						chan_ok_q <= chan_ok;
						mode_q    <= mode;
						tmo_q     <= TIMEOUT_BITS'(timeout_ticks);
						if (kind == KIND_TICK) begin
							addr_q  <= '0;
							state_q <= S_TICK_RD;
						end else if (kind == KIND_SET && chan_ok && mode <= MODE_TOGGLE) begin
							addr_q  <= IDX_W'(channel);
							state_q <= S_SET_RD;
						end else begin
							addr_q  <= IDX_W'(channel);
							state_q <= S_RESP;
						end
					end
				end
				S_SET_RD: begin
					state_q <= S_SET_WR;
				end
				S_SET_WR: begin
					state_q <= S_RESP;
				end
				S_TICK_RD: begin
					state_q <= S_TICK_WR;
				end
				S_TICK_WR: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= chan_q;
						state_q <= S_RESP;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= S_TICK_RD;
					end
				end
				S_RESP: begin
					done_q       <= 1'b1;
					pin_levels_q <= pins_show;
					status_q     <= chan_ok_q ? stat_q[addr_q] : ST_OFF;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
